FILE: rtl/core/hgtm_pkg.sv
// Shared constants, codes and types for the gesture template matcher.
package hgtm_pkg;

   // Sample and template word geometry
   localparam int SAMPLE_BITS = 10;
   localparam int RIGHT_WORDS = 5;
   localparam int ACCEL_WORDS = 3;
   localparam int HAND_W      = RIGHT_WORDS * SAMPLE_BITS;
   localparam int ACCEL_W     = ACCEL_WORDS * SAMPLE_BITS;
   localparam int THR_W       = 10;
   localparam int ENTRY_W     = 6;
   localparam int INDEX_W     = 6;
   localparam int CSR_IDX_W   = 2;

   // Which words of a template take part in a compare
   localparam logic [RIGHT_WORDS-1:0] HAND_USED  = '1;
   localparam logic [RIGHT_WORDS-1:0] ACCEL_USED = RIGHT_WORDS'((1 << ACCEL_WORDS) - 1);

   // Default shape counts
   localparam int DEF_RIGHT_SHAPES = 10;
   localparam int DEF_ACCEL_SHAPES = 3;
   localparam int DEF_LEFT_SHAPES  = 2;

   // Request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_MATCH = 1'b1;

   // Template table selectors
   localparam logic [1:0] TBL_RIGHT = 2'd0;
   localparam logic [1:0] TBL_ACCEL = 2'd1;
   localparam logic [1:0] TBL_LEFT  = 2'd2;

   // Control register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_THR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_THR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_THR  = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef enum logic [1:0] {
      STG_RIGHT,
      STG_ACCEL,
      STG_LEFT
   } stage_type;

endpackage

FILE: rtl/core/hierarchical_gesture_template_matcher.sv
// Gesture template matcher: template tables, scan sequencer and shared compare unit.
//
// Usage: a request is taken at a rising edge with start high and busy low.
// req_type selects a template write or a match. A write stores the packed
// template into the table chosen by req_table_sel at req_entry_index in that
// same edge and gives no response; writes to selector 3 or beyond a table's
// depth are dropped. A match walks the right table, then the accelerometer
// entries under the hit, then the left entries under that hit, one entry per
// cycle through a single compare unit fed by the registered read port of the
// table in use. Busy stays high from the accept edge to the response. The
// response (rsp_matched, rsp_gesture_index) is shown for exactly one cycle
// with rsp_valid; the receiver cannot stall it, and a new request may be
// taken in that same cycle. Threshold registers are to be written through
// csr_we/csr_index/csr_wdata only while idle; the block itself does not
// enforce this. After reset the block clears all template tables, one
// entry per cycle, with busy high; thresholds reset to zero.
module hierarchical_gesture_template_matcher #(
   parameter int RIGHT_SHAPES = hgtm_pkg::DEF_RIGHT_SHAPES,
   parameter int ACCEL_SHAPES = hgtm_pkg::DEF_ACCEL_SHAPES,
   parameter int LEFT_SHAPES  = hgtm_pkg::DEF_LEFT_SHAPES
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_type,
   input  logic [1:0]                        req_table_sel,
   input  logic [hgtm_pkg::ENTRY_W-1:0]      req_entry_index,
   input  logic [hgtm_pkg::HAND_W-1:0]       req_template_packed,
   input  logic [hgtm_pkg::HAND_W-1:0]       req_right_fingers,
   input  logic [hgtm_pkg::HAND_W-1:0]       req_left_fingers,
   input  logic [hgtm_pkg::ACCEL_W-1:0]      req_accel,
   // response channel
   output logic                              rsp_valid,
   output logic                              rsp_matched,
   output logic [hgtm_pkg::INDEX_W-1:0]      rsp_gesture_index,
   // control register port
   input  logic                              csr_we,
   input  logic [hgtm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hgtm_pkg::THR_W-1:0]        csr_wdata
);

   localparam int SB         = hgtm_pkg::SAMPLE_BITS;
   localparam int ACC_DEPTH  = RIGHT_SHAPES * ACCEL_SHAPES;
   localparam int LEFT_DEPTH = ACC_DEPTH * LEFT_SHAPES;
   localparam int AW         = (LEFT_DEPTH > 1) ? $clog2(LEFT_DEPTH) : 1;
   localparam int RA_W       = (RIGHT_SHAPES > 1) ? $clog2(RIGHT_SHAPES) : 1;
   localparam int AA_W       = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
   localparam int IDX_W      = (AW > hgtm_pkg::INDEX_W) ? AW : hgtm_pkg::INDEX_W;
   localparam int MAXS_RA    = (RIGHT_SHAPES > ACCEL_SHAPES) ? RIGHT_SHAPES : ACCEL_SHAPES;
   localparam int MAXS       = (MAXS_RA > LEFT_SHAPES) ? MAXS_RA : LEFT_SHAPES;
   localparam int CW         = $clog2(MAXS + 1);
   localparam int CMPW       = ((AW > hgtm_pkg::ENTRY_W) ? AW : hgtm_pkg::ENTRY_W) + 1;

   // Template stores
   logic [hgtm_pkg::HAND_W-1:0]  right_mem_ff [RIGHT_SHAPES];
   logic [hgtm_pkg::ACCEL_W-1:0] accel_mem_ff [ACC_DEPTH];
   logic [hgtm_pkg::HAND_W-1:0]  left_mem_ff  [LEFT_DEPTH];
   logic [hgtm_pkg::HAND_W-1:0]  rt_rd_ff;
   logic [hgtm_pkg::ACCEL_W-1:0] at_rd_ff;
   logic [hgtm_pkg::HAND_W-1:0]  lt_rd_ff;

   // Sequencer and datapath registers
   hgtm_pkg::state_type          state_ff, state_in;
   hgtm_pkg::stage_type          stage_ff, stage_in;
   logic [CW-1:0]                iss_ff, iss_in;
   logic                         chk_vld_ff, chk_vld_in;
   logic [AW-1:0]                chk_addr_ff, chk_addr_in;
   logic [AW-1:0]                base_ff, base_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic                         matched_ff, matched_in;
   logic [AW-1:0]                clr_ff, clr_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [hgtm_pkg::THR_W-1:0]   right_thr_ff, right_thr_in;
   logic [hgtm_pkg::THR_W-1:0]   accel_thr_ff, accel_thr_in;
   logic [hgtm_pkg::THR_W-1:0]   left_thr_ff, left_thr_in;
   logic [hgtm_pkg::HAND_W-1:0]  right_smp_ff, right_smp_in;
   logic [hgtm_pkg::HAND_W-1:0]  left_smp_ff, left_smp_in;
   logic [hgtm_pkg::ACCEL_W-1:0] accel_smp_ff, accel_smp_in;

   // Combinational helpers
   logic                         req_accept;
   logic [AW-1:0]                rd_addr;
   logic [CW-1:0]                cnt_max;
   logic [CMPW-1:0]              ext_entry;
   logic [AW-1:0]                wr_addr;
   logic                         clearing;
   logic                         rt_we, at_we, lt_we;
   logic [AW-1:0]                mem_waddr;
   logic [hgtm_pkg::HAND_W-1:0]  mem_wdata;
   logic [hgtm_pkg::HAND_W-1:0]  tmpl_sel;
   logic [hgtm_pkg::HAND_W-1:0]  samp_sel;
   logic [hgtm_pkg::THR_W-1:0]   thr_sel;
   logic [hgtm_pkg::RIGHT_WORDS-1:0] word_used;
   logic [hgtm_pkg::RIGHT_WORDS-1:0] word_ok;
   logic                         hit;

   assign req_accept = start && !busy;
   assign busy       = (state_ff != hgtm_pkg::ST_IDLE);
   assign clearing   = (state_ff == hgtm_pkg::ST_CLEAR);
   assign rd_addr    = base_ff + AW'(iss_ff);
   assign ext_entry  = CMPW'(req_entry_index);
   assign wr_addr    = ext_entry[AW-1:0];

   // Drive the response from the result registers
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_matched       = matched_ff;
   assign rsp_gesture_index = idx_ff[hgtm_pkg::INDEX_W-1:0];

   // Pick the write source for the tables: clearing pass or write request
   always_comb begin
      rt_we     = 1'b0;
      at_we     = 1'b0;
      lt_we     = 1'b0;
      mem_waddr = wr_addr;
      mem_wdata = req_template_packed;
      if (clearing) begin
         mem_waddr = clr_ff;
         mem_wdata = '0;
         rt_we     = ({1'b0, clr_ff} < (AW+1)'(RIGHT_SHAPES));
         at_we     = ({1'b0, clr_ff} < (AW+1)'(ACC_DEPTH));
         lt_we     = 1'b1;
      end else if (req_accept && req_type == hgtm_pkg::REQ_WRITE) begin
         rt_we = (req_table_sel == hgtm_pkg::TBL_RIGHT) && (ext_entry < CMPW'(RIGHT_SHAPES));
         at_we = (req_table_sel == hgtm_pkg::TBL_ACCEL) && (ext_entry < CMPW'(ACC_DEPTH));
         lt_we = (req_table_sel == hgtm_pkg::TBL_LEFT) && (ext_entry < CMPW'(LEFT_DEPTH));
      end
   end

   // Right table: one write port, registered read port
   always_ff @(posedge clock) begin
      if (rt_we) begin
         right_mem_ff[mem_waddr[RA_W-1:0]] <= mem_wdata;
      end
      rt_rd_ff <= right_mem_ff[rd_addr[RA_W-1:0]];
   end

   // Accelerometer table: keep three words only
   always_ff @(posedge clock) begin
      if (at_we) begin
         accel_mem_ff[mem_waddr[AA_W-1:0]] <= mem_wdata[hgtm_pkg::ACCEL_W-1:0];
      end
      at_rd_ff <= accel_mem_ff[rd_addr[AA_W-1:0]];
   end

   // Left table
   always_ff @(posedge clock) begin
      if (lt_we) begin
         left_mem_ff[mem_waddr] <= mem_wdata;
      end
      lt_rd_ff <= left_mem_ff[rd_addr];
   end

   // Route the level in use into the shared compare unit
   always_comb begin
      tmpl_sel  = rt_rd_ff;
      samp_sel  = right_smp_ff;
      thr_sel   = right_thr_ff;
      word_used = hgtm_pkg::HAND_USED;
      cnt_max   = CW'(RIGHT_SHAPES);
      unique case (stage_ff)
         hgtm_pkg::STG_RIGHT: begin
            tmpl_sel  = rt_rd_ff;
            samp_sel  = right_smp_ff;
            thr_sel   = right_thr_ff;
            word_used = hgtm_pkg::HAND_USED;
            cnt_max   = CW'(RIGHT_SHAPES);
         end
         hgtm_pkg::STG_ACCEL: begin
            tmpl_sel  = hgtm_pkg::HAND_W'(at_rd_ff);
            samp_sel  = hgtm_pkg::HAND_W'(accel_smp_ff);
            thr_sel   = accel_thr_ff;
            word_used = hgtm_pkg::ACCEL_USED;
            cnt_max   = CW'(ACCEL_SHAPES);
         end
         hgtm_pkg::STG_LEFT: begin
            tmpl_sel  = lt_rd_ff;
            samp_sel  = left_smp_ff;
            thr_sel   = left_thr_ff;
            word_used = hgtm_pkg::HAND_USED;
            cnt_max   = CW'(LEFT_SHAPES);
         end
         default: begin
            cnt_max = CW'(RIGHT_SHAPES);
         end
      endcase
   end

   // Shared compare unit: every used word within threshold, entry not empty
   always_comb begin
      logic [SB-1:0] ta;
      logic [SB-1:0] sa;
      logic [SB-1:0] dd;
      ta = '0;
      sa = '0;
      dd = '0;
      for (int i = 0; i < hgtm_pkg::RIGHT_WORDS; i++) begin
         ta = tmpl_sel[i*SB +: SB];
         sa = samp_sel[i*SB +: SB];
         dd = (ta > sa) ? (ta - sa) : (sa - ta);
         word_ok[i] = (dd <= thr_sel) || !word_used[i];
      end
      hit = (tmpl_sel[SB-1:0] != '0) && (&word_ok);
   end

   // Sequencer: next state, scan control and result
   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      iss_in       = iss_ff;
      chk_vld_in   = chk_vld_ff;
      chk_addr_in  = chk_addr_ff;
      base_in      = base_ff;
      idx_in       = idx_ff;
      matched_in   = matched_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      right_smp_in = right_smp_ff;
      left_smp_in  = left_smp_ff;
      accel_smp_in = accel_smp_ff;

      unique case (state_ff)
         hgtm_pkg::ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(LEFT_DEPTH - 1)) begin
               state_in = hgtm_pkg::ST_IDLE;
            end
         end
         hgtm_pkg::ST_IDLE: begin
            if (req_accept && req_type == hgtm_pkg::REQ_MATCH) begin
               right_smp_in = req_right_fingers;
               left_smp_in  = req_left_fingers;
               accel_smp_in = req_accel;
               state_in     = hgtm_pkg::ST_SCAN;
               stage_in     = hgtm_pkg::STG_RIGHT;
               base_in      = '0;
               iss_in       = '0;
               chk_vld_in   = 1'b0;
               matched_in   = 1'b0;
               idx_in       = '0;
            end
         end
         hgtm_pkg::ST_SCAN: begin
            if (chk_vld_ff && hit) begin
               // descend one level (or finish at the left level), drop the read in flight
               chk_vld_in = 1'b0;
               iss_in     = '0;
               unique case (stage_ff)
                  hgtm_pkg::STG_RIGHT: begin
                     matched_in = 1'b1;
                     idx_in     = IDX_W'(chk_addr_ff * (ACCEL_SHAPES * LEFT_SHAPES));
                     base_in    = AW'(chk_addr_ff * ACCEL_SHAPES);
                     stage_in   = hgtm_pkg::STG_ACCEL;
                  end
                  hgtm_pkg::STG_ACCEL: begin
                     idx_in   = IDX_W'(chk_addr_ff * LEFT_SHAPES);
                     base_in  = AW'(chk_addr_ff * LEFT_SHAPES);
                     stage_in = hgtm_pkg::STG_LEFT;
                  end
                  default: begin
                     idx_in       = IDX_W'(chk_addr_ff);
                     state_in     = hgtm_pkg::ST_IDLE;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end else if (chk_vld_ff && iss_ff == cnt_max) begin
               // level exhausted: keep the fallback index (a right-level miss reports no match, index zero)
               chk_vld_in   = 1'b0;
               state_in     = hgtm_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               if (stage_ff == hgtm_pkg::STG_RIGHT) begin
                  matched_in = 1'b0;
                  idx_in     = '0;
               end
            end else if (iss_ff != cnt_max) begin
               // issue the next entry read
               chk_vld_in  = 1'b1;
               chk_addr_in = rd_addr;
               iss_in      = iss_ff + 1'b1;
            end
         end
         default: begin
            state_in = hgtm_pkg::ST_IDLE;
         end
      endcase
   end

   // Threshold register writes
   always_comb begin
      right_thr_in = right_thr_ff;
      accel_thr_in = accel_thr_ff;
      left_thr_in  = left_thr_ff;
      if (csr_we) begin
         unique case (csr_index)
            hgtm_pkg::CSR_RIGHT_THR: right_thr_in = csr_wdata;
            hgtm_pkg::CSR_ACCEL_THR: accel_thr_in = csr_wdata;
            hgtm_pkg::CSR_LEFT_THR:  left_thr_in  = csr_wdata;
            default: begin
               right_thr_in = right_thr_ff;
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hgtm_pkg::ST_CLEAR;
         stage_ff     <= hgtm_pkg::STG_RIGHT;
         iss_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         matched_ff   <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         right_thr_ff <= '0;
         accel_thr_ff <= '0;
         left_thr_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         iss_ff       <= iss_in;
         chk_vld_ff   <= chk_vld_in;
         matched_ff   <= matched_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         right_thr_ff <= right_thr_in;
         accel_thr_ff <= accel_thr_in;
         left_thr_ff  <= left_thr_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      chk_addr_ff  <= chk_addr_in;
      base_ff      <= base_in;
      idx_ff       <= idx_in;
      right_smp_ff <= right_smp_in;
      left_smp_ff  <= left_smp_in;
      accel_smp_ff <= accel_smp_in;
   end

   // A response only closes a scan
   a_rsp_after_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == hgtm_pkg::ST_SCAN))
      else $error("response without a scan");

   // A miss on the right hand reports index zero
   a_miss_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_matched) |-> (rsp_gesture_index == '0))
      else $error("unmatched response with nonzero index");

   // The block is ready again while the response is shown
   a_rsp_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy while response shown");

   // A read in flight always follows an issued entry
   a_chk_issued: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> (iss_ff != '0) && (state_ff == hgtm_pkg::ST_SCAN))
      else $error("compare without an issued read");

endmodule

FILE: sim/tb_hierarchical_gesture_template_matcher.sv
// Self-checking testbench for the hierarchical gesture template matcher.
module tb_hierarchical_gesture_template_matcher;

   localparam int RIGHT_N     = hgtm_pkg::DEF_RIGHT_SHAPES;
   localparam int ACCEL_N     = hgtm_pkg::DEF_ACCEL_SHAPES;
   localparam int LEFT_N      = hgtm_pkg::DEF_LEFT_SHAPES;
   localparam int ACCEL_DEPTH = RIGHT_N * ACCEL_N;
   localparam int LEFT_DEPTH  = RIGHT_N * ACCEL_N * LEFT_N;
   localparam int WORD_MAX    = (1 << hgtm_pkg::SAMPLE_BITS) - 1;
   localparam int SCAN_CYCLES = RIGHT_N + ACCEL_N + LEFT_N + 3;
   localparam int SETTLE      = SCAN_CYCLES + 4;
   localparam int QUIET_LIMIT = 2000;
   localparam logic [1:0] TBL_NONE = 2'd3;

   typedef struct {
      logic                          kind;
      logic [1:0]                    sel;
      logic [hgtm_pkg::ENTRY_W-1:0]  entry;
      logic [hgtm_pkg::HAND_W-1:0]   tmpl;
      logic [hgtm_pkg::HAND_W-1:0]   right_s;
      logic [hgtm_pkg::HAND_W-1:0]   left_s;
      logic [hgtm_pkg::ACCEL_W-1:0]  accel_s;
   } gesture_req_type;

   typedef struct {
      logic                          hit;
      logic [hgtm_pkg::INDEX_W-1:0]  index;
   } gesture_rsp_type;

   // Template tables, thresholds and the queue of awaited match answers
   class gesture_scoreboard_type;
      logic [hgtm_pkg::HAND_W-1:0]  right_tbl [RIGHT_N];
      logic [hgtm_pkg::ACCEL_W-1:0] accel_tbl [ACCEL_DEPTH];
      logic [hgtm_pkg::HAND_W-1:0]  left_tbl  [LEFT_DEPTH];
      logic [hgtm_pkg::THR_W-1:0]   thr [3];
      gesture_rsp_type              awaited [$];
      int                           errors;

      function new();
         foreach (right_tbl[i]) right_tbl[i] = '0;
         foreach (accel_tbl[i]) accel_tbl[i] = '0;
         foreach (left_tbl[i]) left_tbl[i] = '0;
         foreach (thr[i]) thr[i] = '0;
         errors = 0;
      endfunction

      function void set_threshold(logic [hgtm_pkg::CSR_IDX_W-1:0] idx,
                                  logic [hgtm_pkg::THR_W-1:0] value);
         thr[idx] = value;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // Entry present and every used word within thr of its sample
      function bit hits(logic [hgtm_pkg::HAND_W-1:0] t, logic [hgtm_pkg::HAND_W-1:0] s,
                        int words, logic [hgtm_pkg::THR_W-1:0] limit);
         int a;
         int b;
         if (t[hgtm_pkg::SAMPLE_BITS-1:0] == '0) return 0;
         for (int i = 0; i < words; i++) begin
            a = int'(t[i*hgtm_pkg::SAMPLE_BITS +: hgtm_pkg::SAMPLE_BITS]);
            b = int'(s[i*hgtm_pkg::SAMPLE_BITS +: hgtm_pkg::SAMPLE_BITS]);
            if ((a > b ? a - b : b - a) > int'(limit)) return 0;
         end
         return 1;
      endfunction

      // Apply a write, or walk the template tree and queue the answer
      function void note_request(gesture_req_type q);
         gesture_rsp_type e;
         int ra;
         int aa;
         int la;
         int base;
         bit rf;
         bit af;
         if (q.kind == hgtm_pkg::REQ_WRITE) begin
            case (q.sel)
               hgtm_pkg::TBL_RIGHT:
                  if (q.entry < RIGHT_N) right_tbl[q.entry] = q.tmpl;
               hgtm_pkg::TBL_ACCEL:
                  if (q.entry < ACCEL_DEPTH)
                     accel_tbl[q.entry] = q.tmpl[hgtm_pkg::ACCEL_W-1:0];
               hgtm_pkg::TBL_LEFT:
                  if (q.entry < LEFT_DEPTH) left_tbl[q.entry] = q.tmpl;
               default: ;
            endcase
            return;
         end
         ra = 0;
         aa = 0;
         la = 0;
         rf = 0;
         af = 0;
         for (int r = 0; r < RIGHT_N && !rf; r++)
            if (hits(right_tbl[r], q.right_s, hgtm_pkg::RIGHT_WORDS,
                     thr[hgtm_pkg::CSR_RIGHT_THR])) begin
               rf = 1;
               ra = r;
            end
         e.hit = rf;
         e.index = '0;
         if (rf) begin
            for (int a = 0; a < ACCEL_N && !af; a++)
               if (hits(hgtm_pkg::HAND_W'(accel_tbl[ra*ACCEL_N + a]),
                        hgtm_pkg::HAND_W'(q.accel_s), hgtm_pkg::ACCEL_WORDS,
                        thr[hgtm_pkg::CSR_ACCEL_THR])) begin
                  af = 1;
                  aa = a;
               end
            if (af) begin
               base = (ra*ACCEL_N + aa) * LEFT_N;
               for (int l = LEFT_N - 1; l >= 0; l--)
                  if (hits(left_tbl[base + l], q.left_s, hgtm_pkg::RIGHT_WORDS,
                           thr[hgtm_pkg::CSR_LEFT_THR]))
                     la = l;
            end
            e.index = hgtm_pkg::INDEX_W'((ra*ACCEL_N + aa) * LEFT_N + la);
         end
         awaited.push_back(e);
      endfunction

      // Compare one response with the oldest awaited answer
      function void check_response(logic hit, logic [hgtm_pkg::INDEX_W-1:0] index);
         gesture_rsp_type e;
         if (awaited.size() == 0) begin
            $display("%0t: response with none awaited: matched %0b index %0d",
                     $time, hit, index);
            errors++;
            return;
         end
         e = awaited.pop_front();
         if (hit !== e.hit) begin
            $display("%0t: matched expected %0b actual %0b", $time, e.hit, hit);
            errors++;
         end
         if (index !== e.index) begin
            $display("%0t: gesture_index expected %0d actual %0d", $time, e.index, index);
            errors++;
         end
      endfunction

      function void close_out();
         foreach (awaited[i]) begin
            $display("%0t: answer never came: matched %0b index %0d",
                     $time, awaited[i].hit, awaited[i].index);
            errors++;
         end
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic                           req_type;
   logic [1:0]                     req_table_sel;
   logic [hgtm_pkg::ENTRY_W-1:0]   req_entry_index;
   logic [hgtm_pkg::HAND_W-1:0]    req_template_packed;
   logic [hgtm_pkg::HAND_W-1:0]    req_right_fingers;
   logic [hgtm_pkg::HAND_W-1:0]    req_left_fingers;
   logic [hgtm_pkg::ACCEL_W-1:0]   req_accel;
   logic                           rsp_valid;
   logic                           rsp_matched;
   logic [hgtm_pkg::INDEX_W-1:0]   rsp_gesture_index;
   logic                           csr_we;
   logic [hgtm_pkg::CSR_IDX_W-1:0] csr_index;
   logic [hgtm_pkg::THR_W-1:0]     csr_wdata;

   gesture_scoreboard_type sb = new();
   bit                     sender_idles;
   int                     quiet_cycles;

   hierarchical_gesture_template_matcher dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_type            (req_type),
      .req_table_sel       (req_table_sel),
      .req_entry_index     (req_entry_index),
      .req_template_packed (req_template_packed),
      .req_right_fingers   (req_right_fingers),
      .req_left_fingers    (req_left_fingers),
      .req_accel           (req_accel),
      .rsp_valid           (rsp_valid),
      .rsp_matched         (rsp_matched),
      .rsp_gesture_index   (rsp_gesture_index),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Check every response in the cycle it is shown
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) sb.check_response(rsp_matched, rsp_gesture_index);
   end

   // Abort when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_hierarchical_gesture_template_matcher failed");
         $finish;
      end
   end

   function automatic int table_depth(logic [1:0] sel);
      case (sel)
         hgtm_pkg::TBL_RIGHT: return RIGHT_N;
         hgtm_pkg::TBL_ACCEL: return ACCEL_DEPTH;
         hgtm_pkg::TBL_LEFT:  return LEFT_DEPTH;
         default:             return 64;
      endcase
   endfunction

   // Random template; some entries come out empty
   function automatic logic [hgtm_pkg::HAND_W-1:0] rand_template();
      logic [hgtm_pkg::HAND_W-1:0] v;
      v = hgtm_pkg::HAND_W'({$urandom(), $urandom()});
      if ($urandom_range(0, 99) < 15) v[hgtm_pkg::SAMPLE_BITS-1:0] = '0;
      else if (v[hgtm_pkg::SAMPLE_BITS-1:0] == '0) v[0] = 1'b1;
      return v;
   endfunction

   // Samples near a template: mostly inside the threshold, sometimes just past it
   function automatic logic [hgtm_pkg::HAND_W-1:0] near(logic [hgtm_pkg::HAND_W-1:0] base,
                                                         int words,
                                                         logic [hgtm_pkg::THR_W-1:0] limit);
      logic [hgtm_pkg::HAND_W-1:0] v;
      int w;
      int d;
      v = hgtm_pkg::HAND_W'({$urandom(), $urandom()});
      for (int i = 0; i < words; i++) begin
         w = int'(base[i*hgtm_pkg::SAMPLE_BITS +: hgtm_pkg::SAMPLE_BITS]);
         if ($urandom_range(0, 99) < 85) d = $urandom_range(0, int'(limit));
         else d = int'(limit) + $urandom_range(1, 3);
         if ($urandom_range(0, 1) == 1) w = w + d;
         else w = w - d;
         if (w < 0) w = 0;
         if (w > WORD_MAX) w = WORD_MAX;
         v[i*hgtm_pkg::SAMPLE_BITS +: hgtm_pkg::SAMPLE_BITS] = hgtm_pkg::SAMPLE_BITS'(w);
      end
      return v;
   endfunction

   function automatic gesture_req_type make_write(logic [1:0] sel, int entry,
                                                  logic [hgtm_pkg::HAND_W-1:0] tmpl);
      gesture_req_type q;
      q.kind    = hgtm_pkg::REQ_WRITE;
      q.sel     = sel;
      q.entry   = hgtm_pkg::ENTRY_W'(entry);
      q.tmpl    = tmpl;
      q.right_s = hgtm_pkg::HAND_W'({$urandom(), $urandom()});
      q.left_s  = hgtm_pkg::HAND_W'({$urandom(), $urandom()});
      q.accel_s = hgtm_pkg::ACCEL_W'($urandom());
      return q;
   endfunction

   function automatic gesture_req_type make_match(logic [hgtm_pkg::HAND_W-1:0] rs,
                                                  logic [hgtm_pkg::HAND_W-1:0] ls,
                                                  logic [hgtm_pkg::ACCEL_W-1:0] as);
      gesture_req_type q;
      q.kind    = hgtm_pkg::REQ_MATCH;
      q.sel     = 2'($urandom());
      q.entry   = hgtm_pkg::ENTRY_W'($urandom());
      q.tmpl    = hgtm_pkg::HAND_W'({$urandom(), $urandom()});
      q.right_s = rs;
      q.left_s  = ls;
      q.accel_s = as;
      return q;
   endfunction

   // Present one request and hold it until the block takes it
   task automatic issue(input gesture_req_type q);
      if (sender_idles && $urandom_range(0, 99) < 9) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(0, 19)) @(negedge clock);
      end
      @(negedge clock);
      start               = 1'b1;
      req_type            = q.kind;
      req_table_sel       = q.sel;
      req_entry_index     = q.entry;
      req_template_packed = q.tmpl;
      req_right_fingers   = q.right_s;
      req_left_fingers    = q.left_s;
      req_accel           = q.accel_s;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(q);
   endtask

   // Stop sending and wait for every awaited answer
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (sb.pending() != 0 || busy !== 1'b0) @(posedge clock);
   endtask

   // Write all three thresholds while the block is idle
   task automatic set_thresholds(input int thr_r, input int thr_a, input int thr_l);
      drain();
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = hgtm_pkg::CSR_RIGHT_THR;
      csr_wdata = hgtm_pkg::THR_W'(thr_r);
      sb.set_threshold(hgtm_pkg::CSR_RIGHT_THR, hgtm_pkg::THR_W'(thr_r));
      @(negedge clock);
      csr_index = hgtm_pkg::CSR_ACCEL_THR;
      csr_wdata = hgtm_pkg::THR_W'(thr_a);
      sb.set_threshold(hgtm_pkg::CSR_ACCEL_THR, hgtm_pkg::THR_W'(thr_a));
      @(negedge clock);
      csr_index = hgtm_pkg::CSR_LEFT_THR;
      csr_wdata = hgtm_pkg::THR_W'(thr_l);
      sb.set_threshold(hgtm_pkg::CSR_LEFT_THR, hgtm_pkg::THR_W'(thr_l));
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic random_write();
      logic [1:0] sel;
      int entry;
      if ($urandom_range(0, 99) < 10) sel = TBL_NONE;
      else sel = 2'($urandom_range(0, 2));
      if ($urandom_range(0, 99) < 85) entry = $urandom_range(0, table_depth(sel) - 1);
      else entry = $urandom_range(0, 63);
      issue(make_write(sel, entry, rand_template()));
   endtask

   // Mostly aim at one leaf of the tree, with samples close to its templates; else random samples
   task automatic random_match();
      int r;
      int a;
      int l;
      if ($urandom_range(0, 99) < 15) begin
         issue(make_match(hgtm_pkg::HAND_W'({$urandom(), $urandom()}),
                          hgtm_pkg::HAND_W'({$urandom(), $urandom()}),
                          hgtm_pkg::ACCEL_W'($urandom())));
         return;
      end
      r = $urandom_range(0, RIGHT_N - 1);
      a = $urandom_range(0, ACCEL_N - 1);
      l = $urandom_range(0, LEFT_N - 1);
      issue(make_match(near(sb.right_tbl[r], hgtm_pkg::RIGHT_WORDS,
                            sb.thr[hgtm_pkg::CSR_RIGHT_THR]),
                       near(sb.left_tbl[(r*ACCEL_N + a)*LEFT_N + l], hgtm_pkg::RIGHT_WORDS,
                            sb.thr[hgtm_pkg::CSR_LEFT_THR]),
                       hgtm_pkg::ACCEL_W'(near(hgtm_pkg::HAND_W'(sb.accel_tbl[r*ACCEL_N + a]),
                                               hgtm_pkg::ACCEL_WORDS,
                                               sb.thr[hgtm_pkg::CSR_ACCEL_THR]))));
   endtask

   // One threshold setting: reload all or part of the tables, then a mixed stream
   task automatic run_phase(input int thr_r, input int thr_a, input int thr_l, input bit full,
                            input int count, input bit idles, input bit hold_mid);
      set_thresholds(thr_r, thr_a, thr_l);
      sender_idles = idles;
      if (full) begin
         for (int i = 0; i < RIGHT_N; i++)
            issue(make_write(hgtm_pkg::TBL_RIGHT, i, rand_template()));
         for (int i = 0; i < ACCEL_DEPTH; i++)
            issue(make_write(hgtm_pkg::TBL_ACCEL, i, rand_template()));
         for (int i = 0; i < LEFT_DEPTH; i++)
            issue(make_write(hgtm_pkg::TBL_LEFT, i, rand_template()));
      end else begin
         repeat (25) random_write();
      end
      for (int i = 0; i < count; i++) begin
         if (hold_mid && i == count / 2) drain();
         if ($urandom_range(0, 99) < 10) random_write();
         else random_match();
      end
   endtask

   localparam logic [hgtm_pkg::HAND_W-1:0] ALL_ONES  = '1;
   localparam logic [hgtm_pkg::HAND_W-1:0] EMPTY_TOP =
      {{(hgtm_pkg::HAND_W-hgtm_pkg::SAMPLE_BITS){1'b1}}, {hgtm_pkg::SAMPLE_BITS{1'b0}}};
   localparam logic [hgtm_pkg::HAND_W-1:0] LEFT_PAT  = 50'h1_2345_6789_ABCD;

   initial begin
      logic [hgtm_pkg::HAND_W-1:0] left_off;
      logic [hgtm_pkg::ACCEL_W-1:0] accel_off;
      logic [hgtm_pkg::HAND_W-1:0] right_off;
      reset = 1'b1;
      start = 1'b0;
      req_type = hgtm_pkg::REQ_WRITE;
      req_table_sel = hgtm_pkg::TBL_RIGHT;
      req_entry_index = '0;
      req_template_packed = '0;
      req_right_fingers = '0;
      req_left_fingers = '0;
      req_accel = '0;
      csr_we = 1'b0;
      csr_index = hgtm_pkg::CSR_RIGHT_THR;
      csr_wdata = '0;
      sender_idles = 1'b1;
      quiet_cycles = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // hold off until the table clearing pass is done
      while (busy !== 1'b0) @(posedge clock);

      // Directed: empty tables, empty-entry skip, extremes, fallbacks, dropped writes
      left_off  = LEFT_PAT ^ (hgtm_pkg::HAND_W'(1) << (3*hgtm_pkg::SAMPLE_BITS));
      accel_off = hgtm_pkg::ACCEL_W'(ALL_ONES) ^ (hgtm_pkg::ACCEL_W'(1) << hgtm_pkg::SAMPLE_BITS);
      right_off = ALL_ONES ^ (hgtm_pkg::HAND_W'(1) << (4*hgtm_pkg::SAMPLE_BITS));
      issue(make_match('0, '0, '0));
      issue(make_write(hgtm_pkg::TBL_RIGHT, 0, EMPTY_TOP));
      issue(make_match(EMPTY_TOP, '0, '0));
      issue(make_write(hgtm_pkg::TBL_RIGHT, RIGHT_N - 1, ALL_ONES));
      issue(make_match(ALL_ONES, '0, '0));
      issue(make_write(hgtm_pkg::TBL_ACCEL, ACCEL_DEPTH - 1, ALL_ONES));
      issue(make_write(hgtm_pkg::TBL_LEFT, LEFT_DEPTH - 1, LEFT_PAT));
      issue(make_match(ALL_ONES, LEFT_PAT, hgtm_pkg::ACCEL_W'(ALL_ONES)));
      issue(make_match(ALL_ONES, left_off, hgtm_pkg::ACCEL_W'(ALL_ONES)));
      issue(make_match(ALL_ONES, LEFT_PAT, accel_off));
      issue(make_match(right_off, LEFT_PAT, hgtm_pkg::ACCEL_W'(ALL_ONES)));
      issue(make_write(hgtm_pkg::TBL_RIGHT, 1, hgtm_pkg::HAND_W'(1)));
      issue(make_match(hgtm_pkg::HAND_W'(1), '0, '0));
      issue(make_match('0, '0, '0));
      issue(make_write(TBL_NONE, 1, '0));
      issue(make_write(hgtm_pkg::TBL_RIGHT, RIGHT_N, ALL_ONES));
      issue(make_write(hgtm_pkg::TBL_RIGHT, 63, ALL_ONES));
      issue(make_write(hgtm_pkg::TBL_ACCEL, ACCEL_DEPTH, ALL_ONES));
      issue(make_write(hgtm_pkg::TBL_LEFT, LEFT_DEPTH, ALL_ONES));
      issue(make_match(hgtm_pkg::HAND_W'(1), '0, '0));
      issue(make_match(ALL_ONES, LEFT_PAT, hgtm_pkg::ACCEL_W'(ALL_ONES)));

      // Random phases across threshold settings, extremes included
      run_phase(1023, 1023, 1023, 1'b1, 150, 1'b1, 1'b0);
      run_phase(0, 0, 0, 1'b0, 130, 1'b1, 1'b0);
      run_phase($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                1'b0, 130, 1'b0, 1'b0);
      run_phase($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
                1'b0, 130, 1'b1, 1'b1);
      run_phase(40, 1023, 3, 1'b0, 130, 1'b1, 1'b0);
      run_phase($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
                1'b0, 130, 1'b1, 1'b0);

      // Wind down and report
      drain();
      repeat (SETTLE) @(posedge clock);
      sb.close_out();
      if (sb.errors == 0) $display("tb_hierarchical_gesture_template_matcher passed");
      else $display("tb_hierarchical_gesture_template_matcher failed");
      $finish;
   end

endmodule
